// File: design/bmg_pkg.sv
// Shared constants and types of the bucket maximum gap block.
package bmg_pkg;

  localparam int DATA_W        = 32;
  localparam int DEF_MAX_ITEMS = 1024;

  localparam logic [DATA_W-1:0] SIGN_FLIP = {1'b1, {(DATA_W-1){1'b0}}};

  typedef struct packed {
    logic              used;
    logic [DATA_W-1:0] low;
    logic [DATA_W-1:0] high;
  } bucket_t;

endpackage

// File: design/bucket_maximum_gap_top.sv
// Maximum gap of a value set by pigeonhole buckets, state held in block memories.
//
//  channel   | dir | tdata                 | tuser          | tlast
//  s_axis    | in  | [31:0] value (signed) | -              | last item of the set
//  m_axis    | out | [31:0] max_gap        | [0] overflowed | -
//
// Sequence: one request a cycle while a set loads. After the last request the block
// runs the width and bucket-count divisions, then for each stored value a value read,
// the 32-step shared divider and a bucket read-modify-write, then the scan reads and
// writes back each bucket, which also clears each bucket's used bit.
// Reset: a clearing pass over the bucket memory, no request taken.
// Stalls: the result waits in an output register; loading of the next set carries on.
module bucket_maximum_gap_top
  import bmg_pkg::*;
#(
  parameter int MAX_ITEMS = DEF_MAX_ITEMS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [DATA_W-1:0] s_axis_tdata,   // [31:0] value
  input  logic              s_axis_tlast,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [DATA_W-1:0] m_axis_tdata,   // [31:0] max_gap
  output logic [0:0]        m_axis_tuser    // [0] overflowed
);

  localparam int NB    = 2 * MAX_ITEMS;
  localparam int AW    = $clog2(MAX_ITEMS);
  localparam int BAW   = $clog2(NB);
  localparam int IDX_W = BAW + 1;
  localparam int CNT_W = $clog2(MAX_ITEMS + 1);

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_LOAD  = 4'd1;
  localparam logic [3:0] S_START = 4'd2;
  localparam logic [3:0] S_DIV   = 4'd3;
  localparam logic [3:0] S_WID   = 4'd4;
  localparam logic [3:0] S_NBK   = 4'd5;
  localparam logic [3:0] S_ERD   = 4'd6;
  localparam logic [3:0] S_ESET  = 4'd7;
  localparam logic [3:0] S_BRD   = 4'd8;
  localparam logic [3:0] S_BWR   = 4'd9;
  localparam logic [3:0] S_SRD   = 4'd10;
  localparam logic [3:0] S_SWR   = 4'd11;
  localparam logic [3:0] S_DONE  = 4'd12;

  logic [3:0]        state_q, ret_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [DATA_W-1:0] min_q, max_q, span_q, width_q, v_q, best_q, prev_q;
  logic              lost_q, have_q;
  logic [IDX_W-1:0]  idx_q, nbk_q;
  logic [BAW-1:0]    k_q;
  // shared restoring divider
  logic [DATA_W:0]   rem_q;
  logic [DATA_W-1:0] quo_q, dsr_q;
  logic [4:0]        dcnt_q;
  logic              out_valid_q, out_ovf_q;
  logic [DATA_W-1:0] out_gap_q;

  // memories
  logic [DATA_W-1:0] store_mem [MAX_ITEMS];
  bucket_t           bk_mem    [NB];
  logic [DATA_W-1:0] store_rd_q;
  bucket_t           bk_rd_q;

  logic              in_acc, store_we, bk_we;
  logic [DATA_W-1:0] v_in;
  logic [BAW-1:0]    bk_ra, bk_wa, k_c;
  bucket_t           bk_wd;
  logic [DATA_W:0]   dtrial;
  logic              dge, out_free;

  assign s_axis_tready = (state_q == S_LOAD);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign v_in          = s_axis_tdata ^ SIGN_FLIP;   // offset binary keeps order unsigned
  assign store_we      = in_acc && (cnt_q < CNT_W'(MAX_ITEMS));
  assign out_free      = !out_valid_q || m_axis_tready;

  assign dtrial = {rem_q[DATA_W-1:0], quo_q[DATA_W-1]};
  assign dge    = dtrial >= {1'b0, dsr_q};

  // clamp bucket index to the last bucket
  assign k_c = (quo_q >= DATA_W'(nbk_q)) ? BAW'(nbk_q - 1'b1) : quo_q[BAW-1:0];

  always_comb begin
    bk_ra = idx_q[BAW-1:0];
    bk_wa = idx_q[BAW-1:0];
    bk_we = 1'b0;
    bk_wd = '{used: 1'b0, low: bk_rd_q.low, high: bk_rd_q.high};
    unique case (state_q)
      S_CLR: bk_we = 1'b1;
      S_BRD: bk_ra = k_c;
      S_BWR: begin
        bk_we = 1'b1;
        bk_wa = k_q;
        bk_wd.used = 1'b1;
        if (!bk_rd_q.used) begin
          bk_wd.low  = v_q;
          bk_wd.high = v_q;
        end else begin
          if (v_q < bk_rd_q.low)  bk_wd.low  = v_q;
          if (v_q > bk_rd_q.high) bk_wd.high = v_q;
        end
      end
      S_SWR: bk_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (store_we) store_mem[cnt_q[AW-1:0]] <= v_in;
    store_rd_q <= store_mem[idx_q[AW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (bk_we) bk_mem[bk_wa] <= bk_wd;
    bk_rd_q <= bk_mem[bk_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      ret_q       <= S_CLR;
      cnt_q       <= '0;
      min_q       <= '1;
      max_q       <= '0;
      lost_q      <= 1'b0;
      idx_q       <= '0;
      nbk_q       <= '0;
      have_q      <= 1'b0;
      dcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if ((state_q == S_DONE) && out_free) out_valid_q <= 1'b1;
      else if (m_axis_tready)              out_valid_q <= 1'b0;
      unique case (state_q)
        S_CLR: begin
          if (idx_q == IDX_W'(NB - 1)) begin
            idx_q   <= '0;
            state_q <= S_LOAD;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        S_LOAD: begin
          if (in_acc) begin
            if (store_we) begin
              cnt_q <= cnt_q + 1'b1;
              if (v_in < min_q) min_q <= v_in;
              if (v_in > max_q) max_q <= v_in;
            end else begin
              lost_q <= 1'b1;
            end
            if (s_axis_tlast) state_q <= S_START;
          end
        end
        S_START: begin
          best_q <= '0;
          have_q <= 1'b0;
          idx_q  <= '0;
          if (cnt_q < CNT_W'(2)) begin
            state_q <= S_DONE;
          end else begin
            span_q  <= max_q - min_q;
            rem_q   <= '0;
            quo_q   <= max_q - min_q;
            dsr_q   <= DATA_W'(cnt_q) - DATA_W'(1);
            dcnt_q  <= 5'd31;
            ret_q   <= S_WID;
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          rem_q  <= dge ? (dtrial - {1'b0, dsr_q}) : dtrial;
          quo_q  <= {quo_q[DATA_W-2:0], dge};
          dcnt_q <= dcnt_q - 1'b1;
          if (dcnt_q == 5'd0) state_q <= ret_q;
        end
        S_WID: begin
          width_q <= (quo_q == '0) ? DATA_W'(1) : quo_q;
          dsr_q   <= (quo_q == '0) ? DATA_W'(1) : quo_q;
          rem_q   <= '0;
          quo_q   <= span_q;
          dcnt_q  <= 5'd31;
          ret_q   <= S_NBK;
          state_q <= S_DIV;
        end
        S_NBK: begin
          nbk_q   <= (quo_q >= DATA_W'(NB)) ? IDX_W'(NB) : IDX_W'(quo_q + 1'b1);
          idx_q   <= '0;
          state_q <= S_ERD;
        end
        S_ERD: state_q <= S_ESET;
        S_ESET: begin
          v_q     <= store_rd_q;
          rem_q   <= '0;
          quo_q   <= store_rd_q - min_q;
          dsr_q   <= width_q;
          dcnt_q  <= 5'd31;
          ret_q   <= S_BRD;
          state_q <= S_DIV;
        end
        S_BRD: begin
          k_q     <= k_c;
          state_q <= S_BWR;
        end
        S_BWR: begin
          if (idx_q + 1'b1 == IDX_W'(cnt_q)) begin
            idx_q   <= '0;
            state_q <= S_SRD;
          end else begin
            idx_q   <= idx_q + 1'b1;
            state_q <= S_ERD;
          end
        end
        S_SRD: state_q <= S_SWR;
        S_SWR: begin
          if (bk_rd_q.used) begin
            if (!have_q) begin
              best_q <= bk_rd_q.high - bk_rd_q.low;
              have_q <= 1'b1;
            end else if (bk_rd_q.low - prev_q > best_q) begin
              best_q <= bk_rd_q.low - prev_q;
            end
            prev_q <= bk_rd_q.high;
          end
          idx_q <= idx_q + 1'b1;
          if (idx_q + 1'b1 == nbk_q) state_q <= S_DONE;
          else                       state_q <= S_SRD;
        end
        S_DONE: begin
          if (out_free) begin
            out_gap_q   <= best_q;
            out_ovf_q   <= lost_q;
            cnt_q       <= '0;
            min_q       <= '1;
            max_q       <= '0;
            lost_q      <= 1'b0;
            idx_q       <= '0;
            state_q     <= S_LOAD;
          end
        end
        default: state_q <= S_CLR;
      endcase
    end
  end

  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = out_gap_q;
  assign m_axis_tuser[0] = out_ovf_q;

endmodule

// File: design/bmg_checker.sv
// Port-level checks of the bucket maximum gap block and their binding.
module bmg_checker
  import bmg_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              s_axis_tvalid,
  input logic              s_axis_tready,
  input logic              s_axis_tlast,
  input logic              m_axis_tvalid,
  input logic              m_axis_tready,
  input logic [DATA_W-1:0] m_axis_tdata,
  input logic [0:0]        m_axis_tuser
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // the last request of a set closes the input side
  a_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
    else $error("request taken right after the last one");

  // input side closes only on a last request
  a_close_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(s_axis_tready) |-> $past(s_axis_tvalid && s_axis_tlast))
    else $error("input closed without a last request");

  // a new result appears only while the input side was closed
  a_result_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result raised during loading");

endmodule

bind bucket_maximum_gap_top bmg_checker u_bmg_checker (.*);
